>>> sv/assert_macros.svh
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lbfs assertion failed");
// Clocked property, checked during reset as well
`define ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lbfs assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NR(label, clk, prop)
`endif

`endif

>>> sv/lbfs_pkg.sv
package lbfs_pkg;

   localparam int COLOR_W   = 8;
   localparam int TIME_W    = 16;
   localparam int ELAPSED_W = 17;
   localparam int LED_W     = 10;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int NUM_CHAN  = 4;

   // Register file contents
   typedef struct packed {
      logic [CSR_DW-1:0]  on_color;
      logic [CSR_DW-1:0]  off_color;
      logic [TIME_W-1:0]  on_time_ms;
      logic [TIME_W-1:0]  off_time_ms;
      logic [TIME_W-1:0]  fade_in_ms;
      logic [TIME_W-1:0]  fade_out_ms;
      logic [LED_W-1:0]   first_led;
      logic [LED_W-1:0]   last_led;
   } cfg_type;

   // Sequencer to colour lane controls
   typedef struct packed {
      logic load_en;    // preset level to a colour
      logic load_on;    // 1: lit colour, 0: background colour
      logic start;      // launch step division
      logic apply_en;   // commit faded level
      logic fade_down;  // fade direction is downwards
   } lane_ctl_type;

endpackage

>>> sv/lbfs_csr.sv
module lbfs_csr import lbfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   typedef enum logic [2:0] {
      REG_ON_COLOR,
      REG_OFF_COLOR,
      REG_ON_TIME,
      REG_OFF_TIME,
      REG_FADE_IN,
      REG_FADE_OUT,
      REG_FIRST_LED,
      REG_LAST_LED
   } reg_idx_type;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign reg_idx = reg_idx_type'(paddr[4:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ON_COLOR:  cfg_in.on_color    = pwdata;
            REG_OFF_COLOR: cfg_in.off_color   = pwdata;
            REG_ON_TIME:   cfg_in.on_time_ms  = pwdata[TIME_W-1:0];
            REG_OFF_TIME:  cfg_in.off_time_ms = pwdata[TIME_W-1:0];
            REG_FADE_IN:   cfg_in.fade_in_ms  = pwdata[TIME_W-1:0];
            REG_FADE_OUT:  cfg_in.fade_out_ms = pwdata[TIME_W-1:0];
            REG_FIRST_LED: cfg_in.first_led   = pwdata[LED_W-1:0];
            REG_LAST_LED:  cfg_in.last_led    = pwdata[LED_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Read decode
   always_comb begin
      unique case (reg_idx)
         REG_ON_COLOR:  prdata = cfg_ff.on_color;
         REG_OFF_COLOR: prdata = cfg_ff.off_color;
         REG_ON_TIME:   prdata = {{(CSR_DW-TIME_W){1'b0}}, cfg_ff.on_time_ms};
         REG_OFF_TIME:  prdata = {{(CSR_DW-TIME_W){1'b0}}, cfg_ff.off_time_ms};
         REG_FADE_IN:   prdata = {{(CSR_DW-TIME_W){1'b0}}, cfg_ff.fade_in_ms};
         REG_FADE_OUT:  prdata = {{(CSR_DW-TIME_W){1'b0}}, cfg_ff.fade_out_ms};
         REG_FIRST_LED: prdata = {{(CSR_DW-LED_W){1'b0}}, cfg_ff.first_led};
         REG_LAST_LED:  prdata = {{(CSR_DW-LED_W){1'b0}}, cfg_ff.last_led};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> sv/lbfs_sdiv.sv
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle
module lbfs_sdiv import lbfs_pkg::*; #(
   parameter int N_W = 16,
   parameter int D_W = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic [N_W-1:0] quotient,
   output logic [D_W-1:0] remainder
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [D_W:0]     shifted;
   logic [D_W+1:0]   trial;
   logic             borrow;

   // Trial subtract of the divisor from the partial remainder
   assign shifted = {rem_ff, quo_ff[N_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, div_ff};
   assign borrow  = trial[D_W+1];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[N_W-2:0], ~borrow};
         rem_in  = borrow ? shifted[D_W-1:0] : trial[D_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `ASSERT_CLK(a_start_busy, clock, reset, start |=> busy_ff)
   `ASSERT_CLK(a_busy_count, clock, reset, busy_ff |-> (cnt_ff != '0))

endmodule

>>> sv/lbfs_lane.sv
// One colour channel: level register, step division and clamped fade
module lbfs_lane import lbfs_pkg::*; #(
   parameter int FRAC_W = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [COLOR_W-1:0] on_byte,
   input  logic [COLOR_W-1:0] off_byte,
   input  lane_ctl_type       ctl,
   input  logic [TIME_W-1:0]  ticks,
   output logic               busy,
   output logic [COLOR_W-1:0] fade_level
);

   localparam int LW = COLOR_W + FRAC_W;
   localparam logic [LW:0] FULL = {1'b0, {COLOR_W{1'b1}}, {FRAC_W{1'b0}}};

   logic [LW-1:0]      level_ff, level_in;
   logic [COLOR_W:0]   diff;
   logic               diff_neg;
   logic [COLOR_W:0]   diff_abs;
   logic [LW-1:0]      step_mag;
   logic [LW:0]        sum;
   logic               add_step;
   logic [LW-1:0]      fade_val;

   // Signed colour difference, magnitude goes to the divider
   assign diff     = {1'b0, on_byte} - {1'b0, off_byte};
   assign diff_neg = diff[COLOR_W];
   assign diff_abs = diff_neg ? (~diff + 1'b1) : diff;

   lbfs_sdiv #(
      .N_W (LW),
      .D_W (TIME_W)
   ) u_step_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctl.start),
      .dividend  ({diff_abs[COLOR_W-1:0], {FRAC_W{1'b0}}}),
      .divisor   (ticks),
      .busy      (busy),
      .quotient  (step_mag),
      .remainder ()
   );

   // Step taken upwards when its sign and the direction agree
   assign add_step = (diff_neg == ctl.fade_down);
   assign sum      = {1'b0, level_ff} + {1'b0, step_mag};

   always_comb begin
      if (add_step) begin
         fade_val = (sum > FULL) ? FULL[LW-1:0] : sum[LW-1:0];
      end else begin
         fade_val = (step_mag > level_ff) ? '0 : (level_ff - step_mag);
      end
   end

   assign fade_level = fade_val[LW-1:FRAC_W];

   always_comb begin
      level_in = level_ff;
      if (ctl.load_en) begin
         level_in = {(ctl.load_on ? on_byte : off_byte), {FRAC_W{1'b0}}};
      end else if (ctl.apply_en) begin
         level_in = fade_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

endmodule

>>> sv/led_blink_fade_sequencer_core.sv
// Channel | Direction | Ports                          | Transaction
// req     | in        | req_valid/ready, enable/restart | one refresh tick
// rsp     | out       | rsp_valid/ready, fill fields    | one fill result per tick
// csr     | in/out    | psel, penable, pwrite, paddr... | register write or read
//
// An enabled tick runs the two time dividers, then the four step dividers
// side by side. A disabled tick goes straight to the final state. One tick is
// in flight at a time. Reset is synchronous; lane levels, phase and elapsed
// time clear on reset.
// A finished result waits in the output register; the next tick may be
// accepted meanwhile and stalls only at its end until rsp is free.
`include "assert_macros.svh"

module led_blink_fade_sequencer_core import lbfs_pkg::*; #(
   parameter int REFRESH_MS    = 20,
   parameter int FRACTION_BITS = 12,
   parameter int MAX_LEDS      = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_enable,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_fill_valid,
   output logic [COLOR_W-1:0] rsp_red,
   output logic [COLOR_W-1:0] rsp_green,
   output logic [COLOR_W-1:0] rsp_blue,
   output logic [COLOR_W-1:0] rsp_white,
   output logic [LED_W-1:0]   rsp_span_start,
   output logic [LED_W-1:0]   rsp_span_end,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   localparam int RW = $clog2(REFRESH_MS + 1);
   localparam logic [RW-1:0]        REFRESH_DIV = RW'(REFRESH_MS);
   localparam logic [ELAPSED_W-1:0] HALF_TICK   = ELAPSED_W'(REFRESH_MS / 2);
   localparam logic [ELAPSED_W:0]   TICK_INC    = (ELAPSED_W + 1)'(REFRESH_MS);
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
   localparam logic [LED_W-1:0]     LED_LAST    = LED_W'(MAX_LEDS - 1);

   typedef enum logic [1:0] {S_IDLE, S_TIME, S_STEP, S_FIN} state_type;

   typedef enum logic [2:0] {
      PH_FADE_IN,
      PH_ON,
      PH_HOLD_ON,
      PH_FADE_OUT,
      PH_OFF,
      PH_HOLD_OFF
   } phase_type;

   cfg_type                cfg;
   state_type              st_ff, st_in;
   phase_type              phase_ff, phase_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic                   run_ff, run_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   fill_ff, fill_in;
   logic [COLOR_W-1:0]     lvl_ff [NUM_CHAN];
   logic [COLOR_W-1:0]     lvl_in [NUM_CHAN];
   logic [LED_W-1:0]       start_ff, start_in;
   logic [LED_W-1:0]       end_ff, end_in;

   logic [COLOR_W-1:0]     on_byte  [NUM_CHAN];
   logic [COLOR_W-1:0]     off_byte [NUM_CHAN];
   logic [COLOR_W-1:0]     fade_lvl [NUM_CHAN];
   logic [NUM_CHAN-1:0]    lane_busy;
   lane_ctl_type           lane_ctl;

   phase_type              ph_r, ph_pre;
   logic                   skip_in, skip_out;
   logic [ELAPSED_W-1:0]   el_r, el_pre, el_act;
   logic [ELAPSED_W:0]     el_sum;
   logic                   time_start;
   logic [ELAPSED_W-1:0]   rnd_dividend, rnd_cur;
   logic [ELAPSED_W-1:0]   rnd_quo;
   logic [RW-1:0]          rnd_rem;
   logic [ELAPSED_W-1:0]   round_time;
   logic                   rnd_busy;
   logic [TIME_W-1:0]      tck_dividend, tck_quo, ticks_eff;
   logic                   tck_busy;
   logic [LED_W-1:0]       first_sat, last_sat;
   logic                   fade_ok;

   // Time register that governs a phase
   function automatic logic [TIME_W-1:0] time_sel(phase_type ph, cfg_type c);
      logic [TIME_W-1:0] t;
      case (ph)
         PH_FADE_IN:  t = c.fade_in_ms;
         PH_HOLD_ON:  t = c.on_time_ms;
         PH_FADE_OUT: t = c.fade_out_ms;
         PH_HOLD_OFF: t = c.off_time_ms;
         default:     t = '0;
      endcase
      return t;
   endfunction

   lbfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Restart and zero-fade skips, applied as the tick is accepted
   assign ph_r     = req_restart ? PH_FADE_IN : phase_ff;
   assign el_r     = req_restart ? '0 : elapsed_ff;
   assign skip_in  = (ph_r == PH_FADE_IN) && (cfg.fade_in_ms == '0);
   assign skip_out = (ph_r == PH_FADE_OUT) && (cfg.fade_out_ms == '0);
   assign ph_pre   = skip_in ? PH_ON : (skip_out ? PH_OFF : ph_r);
   assign el_pre   = (skip_in || skip_out) ? '0 : el_r;

   // Rounded time: (t + R/2) less its remainder modulo R
   assign rnd_dividend = {1'b0, time_sel(ph_pre, cfg)} + HALF_TICK;
   assign rnd_cur      = {1'b0, time_sel(phase_ff, cfg)} + HALF_TICK;
   assign round_time   = rnd_cur - {{(ELAPSED_W-RW){1'b0}}, rnd_rem};
   assign tck_dividend = (ph_pre == PH_FADE_OUT) ? cfg.fade_out_ms : cfg.fade_in_ms;
   assign ticks_eff    = (tck_quo == '0) ? TIME_W'(1) : tck_quo;

   lbfs_sdiv #(
      .N_W (ELAPSED_W),
      .D_W (RW)
   ) u_round_div (
      .clock     (clock),
      .reset     (reset),
      .start     (time_start),
      .dividend  (rnd_dividend),
      .divisor   (REFRESH_DIV),
      .busy      (rnd_busy),
      .quotient  (rnd_quo),
      .remainder (rnd_rem)
   );

   lbfs_sdiv #(
      .N_W (TIME_W),
      .D_W (RW)
   ) u_ticks_div (
      .clock     (clock),
      .reset     (reset),
      .start     (time_start),
      .dividend  (tck_dividend),
      .divisor   (REFRESH_DIV),
      .busy      (tck_busy),
      .quotient  (tck_quo),
      .remainder ()
   );

   // Colour lanes: red, green, blue, white from the top byte down
   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
      assign on_byte[c]  = cfg.on_color[CSR_DW-1-COLOR_W*c -: COLOR_W];
      assign off_byte[c] = cfg.off_color[CSR_DW-1-COLOR_W*c -: COLOR_W];

      lbfs_lane #(
         .FRAC_W (FRACTION_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .on_byte    (on_byte[c]),
         .off_byte   (off_byte[c]),
         .ctl        (lane_ctl),
         .ticks      (ticks_eff),
         .busy       (lane_busy[c]),
         .fade_level (fade_lvl[c])
      );
   end

   // Span saturated to the strip length
   assign first_sat = (32'(cfg.first_led) > 32'(MAX_LEDS - 1)) ? LED_LAST : cfg.first_led;
   assign last_sat  = (32'(cfg.last_led) > 32'(MAX_LEDS - 1)) ? LED_LAST : cfg.last_led;

   assign fade_ok = (elapsed_ff <= round_time);
   assign el_sum  = {1'b0, el_act} + TICK_INC;

   // Sequencer next state
   always_comb begin
      st_in        = st_ff;
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      fill_in      = fill_ff;
      lvl_in       = lvl_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      time_start   = 1'b0;
      lane_ctl     = '0;
      el_act       = elapsed_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               run_in = req_enable;
               if (req_enable) begin
                  phase_in         = ph_pre;
                  elapsed_in       = el_pre;
                  lane_ctl.load_en = req_restart || skip_in || skip_out;
                  lane_ctl.load_on = skip_in;
                  time_start       = 1'b1;
                  st_in            = S_TIME;
               end else begin
                  st_in = S_FIN;
               end
            end
         end
         S_TIME: begin
            if (!rnd_busy && !tck_busy) begin
               lane_ctl.start = 1'b1;
               st_in          = S_STEP;
            end
         end
         S_STEP: begin
            if (lane_busy == '0) begin
               st_in = S_FIN;
            end
         end
         S_FIN: begin
            lane_ctl.fade_down = (phase_ff == PH_FADE_OUT);
            if (!rsp_valid_ff || rsp_ready) begin
               st_in        = S_IDLE;
               rsp_valid_in = 1'b1;
               fill_in      = 1'b0;
               start_in     = '0;
               end_in       = '0;
               for (int c = 0; c < NUM_CHAN; c++) begin
                  lvl_in[c] = '0;
               end
               if (run_ff) begin
                  unique case (phase_ff) inside
                     PH_FADE_IN, PH_FADE_OUT: begin
                        if (fade_ok) begin
                           lane_ctl.apply_en = 1'b1;
                           fill_in           = 1'b1;
                           lvl_in            = fade_lvl;
                        end else begin
                           phase_in = (phase_ff == PH_FADE_IN) ? PH_ON : PH_OFF;
                           el_act   = '0;
                        end
                     end
                     PH_ON: begin
                        fill_in  = 1'b1;
                        lvl_in   = on_byte;
                        phase_in = PH_HOLD_ON;
                     end
                     PH_OFF: begin
                        fill_in  = 1'b1;
                        lvl_in   = off_byte;
                        phase_in = PH_HOLD_OFF;
                     end
                     PH_HOLD_ON, PH_HOLD_OFF: begin
                        if (elapsed_ff > round_time) begin
                           phase_in = (phase_ff == PH_HOLD_ON) ? PH_FADE_OUT : PH_FADE_IN;
                           el_act   = '0;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
                  if (fill_in) begin
                     start_in = first_sat;
                     end_in   = last_sat;
                  end
                  elapsed_in = el_sum[ELAPSED_W] ? ELAPSED_MAX : el_sum[ELAPSED_W-1:0];
               end
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      fill_ff  <= fill_in;
      lvl_ff   <= lvl_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      if (reset) begin
         st_ff        <= S_IDLE;
         phase_ff     <= PH_FADE_IN;
         elapsed_ff   <= '0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready      = (st_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fill_valid = fill_ff;
   assign rsp_red        = lvl_ff[0];
   assign rsp_green      = lvl_ff[1];
   assign rsp_blue       = lvl_ff[2];
   assign rsp_white      = lvl_ff[3];
   assign rsp_span_start = start_ff;
   assign rsp_span_end   = end_ff;

   `ASSERT_CLK(a_one_in_flight, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `ASSERT_CLK(a_idle_quiet, clock, reset,
      (st_ff == S_IDLE) |-> ((lane_busy == '0) && !rnd_busy && !tck_busy))
   `ASSERT_CLK(a_nofill_zero, clock, reset,
      (rsp_valid && !rsp_fill_valid) |-> ((rsp_red == '0) && (rsp_white == '0) && (rsp_span_end == '0)))

endmodule

>>> sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lbfs_pkg::*;

   localparam int CLK_PERIOD    = 12;
   localparam int REFRESH_MS    = 20;
   localparam int FRAC_BITS     = 12;
   localparam int SPAN_MAX      = 1023;
   localparam int ELAPSED_LIMIT = (1 << ELAPSED_W) - 1;
   localparam int FULL_SCALE    = 255 << FRAC_BITS;
   localparam int NUM_REGS      = 8;

   // sequencer phases
   typedef enum logic [2:0] {
      SEQ_FADE_UP   = 3'd0,
      SEQ_LIT       = 3'd1,
      SEQ_LIT_HOLD  = 3'd2,
      SEQ_FADE_DOWN = 3'd3,
      SEQ_DARK      = 3'd4,
      SEQ_DARK_HOLD = 3'd5
   } seq_phase_e;

   // register indexes, byte address is 4 * index
   typedef enum logic [2:0] {
      REG_ON_COLOR  = 3'd0,
      REG_OFF_COLOR = 3'd1,
      REG_ON_TIME   = 3'd2,
      REG_OFF_TIME  = 3'd3,
      REG_FADE_IN   = 3'd4,
      REG_FADE_OUT  = 3'd5,
      REG_FIRST_LED = 3'd6,
      REG_LAST_LED  = 3'd7
   } csr_reg_e;

   typedef struct packed {
      logic               fill;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] white;
      logic [LED_W-1:0]   span_start;
      logic [LED_W-1:0]   span_end;
   } fill_t;

   // DUT signals, all inputs known from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_enable = 1'b0;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_fill_valid;
   logic [COLOR_W-1:0] rsp_red, rsp_green, rsp_blue, rsp_white;
   logic [LED_W-1:0]   rsp_span_start, rsp_span_end;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [CSR_AW-1:0]  paddr = '0;
   logic [CSR_DW-1:0]  pwdata = '0;
   logic [CSR_DW-1:0]  prdata;
   logic               pready;

   // predictor state
   cfg_type                cfg;
   seq_phase_e             seq_phase;
   logic [ELAPSED_W-1:0]   seq_elapsed;
   logic [19:0]            seq_level [NUM_CHAN];

   fill_t fill_expect [$];
   int    error_count = 0;
   bit    steady = 1'b0;      // no idling on either side while set
   int    rsp_stall_req = 0;  // receiver hold-off request, in cycles

   led_blink_fade_sequencer_core #(
      .REFRESH_MS    (REFRESH_MS),
      .FRACTION_BITS (FRAC_BITS),
      .MAX_LEDS      (SPAN_MAX + 1)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_enable     (req_enable),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_fill_valid (rsp_fill_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_white      (rsp_white),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   function automatic int color_lane(logic [31:0] color, int c);
      return int'(color[31 - 8 * c -: 8]);
   endfunction

   // ms rounded to the nearest refresh multiple, halves up
   function automatic int snap_ms(logic [TIME_W-1:0] ms);
      int r;
      r = ((int'(ms) + REFRESH_MS / 2) / REFRESH_MS) * REFRESH_MS;
      return (r > ELAPSED_LIMIT) ? ELAPSED_LIMIT : r;
   endfunction

   function automatic void preset_levels(logic [31:0] color);
      for (int c = 0; c < NUM_CHAN; c++)
         seq_level[c] = 20'(color_lane(color, c) << FRAC_BITS);
   endfunction

   // one linear step per lane, clamped to 0..255.0
   function automatic void ramp_levels(logic [TIME_W-1:0] ms, int dir);
      int ticks, diff, stp, v;
      ticks = int'(ms) / REFRESH_MS;
      if (ticks == 0) ticks = 1;
      for (int c = 0; c < NUM_CHAN; c++) begin
         diff = color_lane(cfg.on_color, c) - color_lane(cfg.off_color, c);
         stp  = (diff * (1 << FRAC_BITS)) / ticks;
         v    = int'(seq_level[c]) + dir * stp;
         if (v > FULL_SCALE) v = FULL_SCALE;
         if (v < 0) v = 0;
         seq_level[c] = v[19:0];
      end
   endfunction

   function automatic fill_t make_fill(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic [7:0] w);
      fill_t f;
      f.fill       = 1'b1;
      f.red        = r;
      f.green      = g;
      f.blue       = b;
      f.white      = w;
      f.span_start = (cfg.first_led > SPAN_MAX) ? LED_W'(SPAN_MAX) : cfg.first_led;
      f.span_end   = (cfg.last_led > SPAN_MAX) ? LED_W'(SPAN_MAX) : cfg.last_led;
      return f;
   endfunction

   function automatic fill_t level_fill();
      return make_fill(seq_level[0][FRAC_BITS +: 8], seq_level[1][FRAC_BITS +: 8],
                       seq_level[2][FRAC_BITS +: 8], seq_level[3][FRAC_BITS +: 8]);
   endfunction

   function automatic fill_t color_fill(logic [31:0] color);
      return make_fill(color[31:24], color[23:16], color[15:8], color[7:0]);
   endfunction

   // advances the sequencer by one tick and returns the fill it issues
   function automatic fill_t predict_tick(logic en, logic rs);
      fill_t f;
      int    el;
      f = '0;
      if (!en) return f;

      if (rs) begin
         seq_elapsed = '0;
         seq_phase   = SEQ_FADE_UP;
         preset_levels(cfg.off_color);
      end
      // zero fade times skip straight to the target colour
      if (cfg.fade_in_ms == 0 && seq_phase == SEQ_FADE_UP) begin
         seq_phase   = SEQ_LIT;
         seq_elapsed = '0;
         preset_levels(cfg.on_color);
      end
      if (cfg.fade_out_ms == 0 && seq_phase == SEQ_FADE_DOWN) begin
         seq_phase   = SEQ_DARK;
         seq_elapsed = '0;
         preset_levels(cfg.off_color);
      end

      case (seq_phase)
         SEQ_FADE_UP: begin
            if (int'(seq_elapsed) <= snap_ms(cfg.fade_in_ms)) begin
               ramp_levels(cfg.fade_in_ms, 1);
               f = level_fill();
            end else begin
               seq_phase   = SEQ_LIT;
               seq_elapsed = '0;
            end
         end
         SEQ_LIT: begin
            f = color_fill(cfg.on_color);
            seq_phase = SEQ_LIT_HOLD;
         end
         SEQ_LIT_HOLD: begin
            if (int'(seq_elapsed) > snap_ms(cfg.on_time_ms)) begin
               seq_phase   = SEQ_FADE_DOWN;
               seq_elapsed = '0;
            end
         end
         SEQ_FADE_DOWN: begin
            if (int'(seq_elapsed) <= snap_ms(cfg.fade_out_ms)) begin
               ramp_levels(cfg.fade_out_ms, -1);
               f = level_fill();
            end else begin
               seq_phase   = SEQ_DARK;
               seq_elapsed = '0;
            end
         end
         SEQ_DARK: begin
            f = color_fill(cfg.off_color);
            seq_phase = SEQ_DARK_HOLD;
         end
         SEQ_DARK_HOLD: begin
            if (int'(seq_elapsed) > snap_ms(cfg.off_time_ms)) begin
               seq_phase   = SEQ_FADE_UP;
               seq_elapsed = '0;
            end
         end
         default: ;
      endcase

      el = int'(seq_elapsed) + REFRESH_MS;
      seq_elapsed = (el > ELAPSED_LIMIT) ? ELAPSED_W'(ELAPSED_LIMIT) : el[ELAPSED_W-1:0];
      return f;
   endfunction

   function automatic logic [CSR_DW-1:0] csr_image(cfg_type c, csr_reg_e idx);
      case (idx)
         REG_ON_COLOR:  return c.on_color;
         REG_OFF_COLOR: return c.off_color;
         REG_ON_TIME:   return CSR_DW'(c.on_time_ms);
         REG_OFF_TIME:  return CSR_DW'(c.off_time_ms);
         REG_FADE_IN:   return CSR_DW'(c.fade_in_ms);
         REG_FADE_OUT:  return CSR_DW'(c.fade_out_ms);
         REG_FIRST_LED: return CSR_DW'(c.first_led);
         default:       return CSR_DW'(c.last_led);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
      error_count++;
   endtask

   task automatic check_fill();
      fill_t want;
      if (fill_expect.size() == 0) begin
         report_mismatch("fill with nothing outstanding", 0, 1);
         return;
      end
      want = fill_expect.pop_front();
      if (rsp_fill_valid !== want.fill)
         report_mismatch("fill_valid", want.fill, rsp_fill_valid);
      if (rsp_red !== want.red)          report_mismatch("red", want.red, rsp_red);
      if (rsp_green !== want.green)      report_mismatch("green", want.green, rsp_green);
      if (rsp_blue !== want.blue)        report_mismatch("blue", want.blue, rsp_blue);
      if (rsp_white !== want.white)      report_mismatch("white", want.white, rsp_white);
      if (rsp_span_start !== want.span_start)
         report_mismatch("span_start", want.span_start, rsp_span_start);
      if (rsp_span_end !== want.span_end)
         report_mismatch("span_end", want.span_end, rsp_span_end);
   endtask

   // result side: random ready, long hold-offs on request
   initial begin : rsp_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_fill();
         if (rsp_stall_req > 0) begin
            hold_left     = rsp_stall_req;
            rsp_stall_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (reset) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 32);
         end
      end
   end

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------

   // one tick transaction; valid stays high into the next one if no gap
   task automatic send_tick(logic en, logic rs);
      while (!steady && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_enable  <= en;
      req_restart <= rs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      fill_expect.push_back(predict_tick(en, rs));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (fill_expect.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(csr_reg_e idx, logic is_write, logic [CSR_DW-1:0] wdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (is_write) begin
         case (idx)
            REG_ON_COLOR:  cfg.on_color    = wdata;
            REG_OFF_COLOR: cfg.off_color   = wdata;
            REG_ON_TIME:   cfg.on_time_ms  = wdata[TIME_W-1:0];
            REG_OFF_TIME:  cfg.off_time_ms = wdata[TIME_W-1:0];
            REG_FADE_IN:   cfg.fade_in_ms  = wdata[TIME_W-1:0];
            REG_FADE_OUT:  cfg.fade_out_ms = wdata[TIME_W-1:0];
            REG_FIRST_LED: cfg.first_led   = wdata[LED_W-1:0];
            default:       cfg.last_led    = wdata[LED_W-1:0];
         endcase
      end else if (prdata !== csr_image(cfg, idx)) begin
         report_mismatch($sformatf("readback of register %s", idx.name()),
                         csr_image(cfg, idx), prdata);
      end
   endtask

   // writes every register while idle, then reads them all back
   task automatic apply_settings(cfg_type want);
      for (int i = 0; i < NUM_REGS; i++)
         csr_access(csr_reg_e'(i), 1'b1, csr_image(want, csr_reg_e'(i)));
      for (int i = 0; i < NUM_REGS; i++)
         csr_access(csr_reg_e'(i), 1'b0, '0);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_color();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // mostly short times so whole blink cycles fit in a phase
   function automatic logic [TIME_W-1:0] pick_ms();
      int r;
      r = $urandom_range(99);
      if (r < 15) return '0;
      if (r < 20) return '1;
      if (r < 25) return TIME_W'($urandom);
      return TIME_W'($urandom_range(1, 160));
   endfunction

   function automatic cfg_type pick_settings();
      cfg_type c;
      c.on_color    = pick_color();
      c.off_color   = pick_color();
      c.on_time_ms  = pick_ms();
      c.off_time_ms = pick_ms();
      c.fade_in_ms  = pick_ms();
      c.fade_out_ms = pick_ms();
      c.first_led   = LED_W'($urandom_range(0, SPAN_MAX));
      c.last_led    = LED_W'($urandom_range(0, SPAN_MAX));
      return c;
   endfunction

   // mostly enabled ticks, a few disabled ones and restarts
   task automatic send_random_ticks(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 8)       send_tick(1'b0, $urandom_range(1));
         else if (r < 12) send_tick(1'b1, 1'b1);
         else             send_tick(1'b1, 1'b0);
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // state after reset: zero fades skip, zero colours, zero holds
   task automatic test_reset_defaults();
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      repeat (4) send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      wait_drained();
   endtask

   // full swing up with overshoot clamped at 255, rounding of short times
   task automatic test_full_swing();
      cfg_type c;
      c.on_color    = 32'hFFFF_FFFF;
      c.off_color   = 32'h0000_0000;
      c.on_time_ms  = 16'd10;
      c.off_time_ms = 16'd9;
      c.fade_in_ms  = 16'd20;
      c.fade_out_ms = 16'd30;
      c.first_led   = '0;
      c.last_led    = LED_W'(SPAN_MAX);
      apply_settings(c);
      send_tick(1'b1, 1'b1);
      repeat (5) send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      repeat (5) send_tick(1'b1, 1'b0);
      wait_drained();
   endtask

   // downward colours, longest times and inverted span
   task automatic test_inverse_extremes();
      cfg_type c;
      c.on_color    = 32'h0000_0000;
      c.off_color   = 32'hFFFF_FFFF;
      c.on_time_ms  = '1;
      c.off_time_ms = '1;
      c.fade_in_ms  = '1;
      c.fade_out_ms = '1;
      c.first_led   = LED_W'(SPAN_MAX);
      c.last_led    = '0;
      apply_settings(c);
      send_tick(1'b1, 1'b1);
      repeat (3) send_tick(1'b1, 1'b0);
      wait_drained();
   endtask

   task automatic test_random_sequences();
      for (int s = 0; s < 12; s++) begin
         apply_settings(pick_settings());
         send_tick(1'b1, 1'b1);
         send_random_ticks(130);
         wait_drained();
      end
   endtask

   // receiver holds off while ticks keep coming, then a full drain
   task automatic test_backpressure();
      apply_settings(pick_settings());
      rsp_stall_req = 400;
      send_tick(1'b1, 1'b1);
      send_random_ticks(40);
      wait_drained();
   endtask

   // long run with no idling on either side
   task automatic test_steady_stream();
      apply_settings(pick_settings());
      steady = 1'b1;
      send_tick(1'b1, 1'b1);
      send_random_ticks(220);
      wait_drained();
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------

   initial begin : main_seq
      cfg         = '0;
      seq_phase   = SEQ_FADE_UP;
      seq_elapsed = '0;
      preset_levels(32'h0000_0000);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_full_swing();
      test_inverse_extremes();
      test_random_sequences();
      test_backpressure();
      test_steady_stream();

      wait_drained();
      repeat (64) @(posedge clock);
      if (fill_expect.size() != 0)
         report_mismatch("fills still outstanding", 0, fill_expect.size());
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #15ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
